// ----- src/fcpf_pkg.sv -----
// Package for the firmware chunk framer: constants, the queue word type and
// the back-end phase type. No dependencies.

package fcpf_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 10;
	localparam int PKT_W       = 16;
	localparam int CHUNK_BYTES = 990;
	localparam int TOTAL_ADD   = 12;
	localparam int INNER_ADD   = 9;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [BYTE_W-1:0] HDR_PROTO = 8'h80;
	localparam logic [BYTE_W-1:0] HDR_ONE   = 8'h01;
	localparam logic [BYTE_W-1:0] HDR_ZERO  = 8'h00;

	// one classified input word, as handed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              first;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic [PKT_W-1:0]  pkt;
	} cmd_t;

	typedef enum logic [3:0] {
		PH_TLEN_HI,
		PH_TLEN_LO,
		PH_PROTO,
		PH_ONE_A,
		PH_ONE_B,
		PH_ILEN_HI,
		PH_ILEN_LO,
		PH_ZERO,
		PH_PKT_HI,
		PH_PKT_LO,
		PH_DATA,
		PH_OR,
		PH_XOR
	} phase_t;

endpackage

// ----- src/fcpf_if.sv -----
// Valid/ready channel interfaces for the framer's input and output words.
// Depends on fcpf_pkg.

interface fcpf_in_if import fcpf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic [LEN_W-1:0]  chunk_length;
	logic              new_file;

	modport source(output valid, output data_byte, output chunk_length, output new_file,
		input ready);
	modport sink(input valid, input data_byte, input chunk_length, input new_file,
		output ready);
endinterface

interface fcpf_out_if import fcpf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              end_of_frame;

	modport source(output valid, output out_byte, output end_of_frame, input ready);
	modport sink(input valid, input out_byte, input end_of_frame, output ready);
endinterface

// ----- src/fcpf_front.sv -----
// Front end: accepts input words, tracks chunk position and packet number,
// and classifies each word (first/last of chunk). Depends on fcpf_pkg, fcpf_if.

module fcpf_front import fcpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fcpf_in_if.sink    in_ch,
	output cmd_t       cmd,
	output logic       cmd_valid,
	input  logic       cmd_ready
);

	logic [LEN_W-1:0] pos_q;
	logic [PKT_W-1:0] pkt_q;
	logic [LEN_W-1:0] len_sat;
	logic [LEN_W-1:0] pos_inc;
	logic [PKT_W-1:0] pkt_use;
	logic             first;
	logic             last;
	logic             accept;

	always_comb begin
		priority if (in_ch.chunk_length == '0) begin
			len_sat = LEN_W'(1);
		end else if (in_ch.chunk_length > LEN_W'(CHUNK_BYTES)) begin
			len_sat = LEN_W'(CHUNK_BYTES);
		end else begin
			len_sat = in_ch.chunk_length;
		end
	end

	assign first   = (pos_q == '0);
	assign pos_inc = pos_q + LEN_W'(1);
	assign last    = (pos_inc >= len_sat);
	// new_file only counts on the first byte of a chunk
	assign pkt_use = (first && in_ch.new_file) ? '0 : pkt_q;

	assign in_ch.ready = cmd_ready;
	assign cmd_valid   = in_ch.valid;
	assign accept      = in_ch.valid && cmd_ready;

	assign cmd.data  = in_ch.data_byte;
	assign cmd.first = first;
	assign cmd.last  = last;
	assign cmd.len   = len_sat;
	assign cmd.pkt   = pkt_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pkt_q <= '0;
		end else if (accept) begin
			pos_q <= last ? '0 : pos_inc;
			pkt_q <= last ? pkt_use + PKT_W'(1) : pkt_use;
		end
	end

	// position always stays inside a legal chunk
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < LEN_W'(CHUNK_BYTES))
		else $error("chunk position out of range");

endmodule

// ----- src/fcpf_fifo.sv -----
// Short queue of classified words between front and back end.
// Depends on fcpf_pkg.

module fcpf_fifo import fcpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output cmd_t pop_data,
	output logic pop_valid,
	input  logic pop
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != FIFO_CW'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count above depth");

endmodule

// ----- src/fcpf_back.sv -----
// Back end: expands each queued word into header, data and trailer bytes,
// keeps the OR/XOR sums, and drives the output register. Depends on fcpf_pkg, fcpf_if.

module fcpf_back import fcpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_valid,
	output logic       pop,
	fcpf_out_if.source out_ch
);

	cmd_t              cur_q;
	logic              cur_valid_q;
	phase_t            phase_q;
	phase_t            phase_d;
	logic [BYTE_W-1:0] or_q;
	logic [BYTE_W-1:0] xor_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              eof_q;

	logic              out_free;
	logic              emit;
	logic              done;
	logic [BYTE_W-1:0] byte_d;
	logic              eof_d;
	logic              sum_start;
	logic              sum_acc;
	logic [PKT_W-1:0]  total;
	logic [PKT_W-1:0]  inner;

	assign out_free = !out_valid_q || out_ch.ready;
	assign emit     = cur_valid_q && out_free;
	assign pop      = head_valid && (!cur_valid_q || (emit && done));
	assign total    = PKT_W'(cur_q.len) + PKT_W'(TOTAL_ADD);
	assign inner    = PKT_W'(cur_q.len) + PKT_W'(INNER_ADD);

	// next phase
	always_comb begin
		phase_d = phase_q;
		done    = 1'b0;
		if (emit) begin
			unique case (phase_q)
				PH_TLEN_HI: phase_d = PH_TLEN_LO;
				PH_TLEN_LO: phase_d = PH_PROTO;
				PH_PROTO:   phase_d = PH_ONE_A;
				PH_ONE_A:   phase_d = PH_ONE_B;
				PH_ONE_B:   phase_d = PH_ILEN_HI;
				PH_ILEN_HI: phase_d = PH_ILEN_LO;
				PH_ILEN_LO: phase_d = PH_ZERO;
				PH_ZERO:    phase_d = PH_PKT_HI;
				PH_PKT_HI:  phase_d = PH_PKT_LO;
				PH_PKT_LO:  phase_d = PH_DATA;
				PH_DATA: begin
					if (cur_q.last) begin
						phase_d = PH_OR;
					end else begin
						done = 1'b1;
					end
				end
				PH_OR:      phase_d = PH_XOR;
				PH_XOR:     done = 1'b1;
				default:    done = 1'b1;
			endcase
		end
		if (pop) begin
			phase_d = head.first ? PH_TLEN_HI : PH_DATA;
		end
	end

	// byte for the current phase
	always_comb begin
		byte_d    = HDR_ZERO;
		eof_d     = 1'b0;
		sum_start = 1'b0;
		sum_acc   = 1'b0;
		unique case (phase_q)
			PH_TLEN_HI: byte_d = total[15:8];
			PH_TLEN_LO: byte_d = total[7:0];
			PH_PROTO:   byte_d = HDR_PROTO;
			PH_ONE_A: begin
				byte_d    = HDR_ONE;
				sum_start = 1'b1;
			end
			PH_ONE_B: begin
				byte_d  = HDR_ONE;
				sum_acc = 1'b1;
			end
			PH_ILEN_HI: begin
				byte_d  = inner[15:8];
				sum_acc = 1'b1;
			end
			PH_ILEN_LO: begin
				byte_d  = inner[7:0];
				sum_acc = 1'b1;
			end
			PH_ZERO: begin
				byte_d  = HDR_ZERO;
				sum_acc = 1'b1;
			end
			PH_PKT_HI: begin
				byte_d  = cur_q.pkt[15:8];
				sum_acc = 1'b1;
			end
			PH_PKT_LO: begin
				byte_d  = cur_q.pkt[7:0];
				sum_acc = 1'b1;
			end
			PH_DATA: begin
				byte_d  = cur_q.data;
				sum_acc = 1'b1;
			end
			PH_OR:      byte_d = or_q;
			PH_XOR: begin
				byte_d = xor_q;
				eof_d  = 1'b1;
			end
			default:    byte_d = HDR_ZERO;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (emit) begin
			out_byte_q <= byte_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q     <= PH_DATA;
			or_q        <= '0;
			xor_q       <= '0;
			out_valid_q <= 1'b0;
			eof_q       <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (emit && done) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				eof_q       <= eof_d;
				if (sum_start) begin
					or_q  <= byte_d;
					xor_q <= byte_d;
				end else if (sum_acc) begin
					or_q  <= or_q | byte_d;
					xor_q <= xor_q ^ byte_d;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_byte     = out_byte_q;
	assign out_ch.end_of_frame = eof_q;

	// trailer only follows the last data byte of a chunk
	a_trailer_last: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && (phase_q == PH_OR || phase_q == PH_XOR) |-> cur_q.last)
		else $error("trailer on a word that does not end its chunk");

	// header only for the first byte of a chunk
	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && phase_q == PH_TLEN_HI |-> cur_q.first)
		else $error("header on a word that does not start its chunk");

endmodule

// ----- src/firmware_chunk_packet_framer_core.sv -----
// Firmware chunk framer, top level: front end, word queue, back end.
// A word passes the queue and the current-word register to the output register.
// Throughput: one input word per cycle while the 4-word queue has room; one byte
// out per cycle while out_ch is ready; a chunk of L bytes gives L + 12 bytes out.
// Reset (arst_n, async, active low) clears position, packet number, sums, queue.

module firmware_chunk_packet_framer_core import fcpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fcpf_in_if.sink    in_ch,
	fcpf_out_if.source out_ch
);

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t head;
	logic head_valid;
	logic pop;

	fcpf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	fcpf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (head),
		.pop_valid  (head_valid),
		.pop        (pop)
	);

	fcpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

// ----- sim/fcpf_frame_check.sv -----
`timescale 1ns / 100ps
// Frame checker for the firmware chunk framer: predicts the framed byte stream
// from accepted input words and compares every accepted output word. Uses fcpf_pkg.

module fcpf_frame_check import fcpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fcpf_in_if   in_ch,
	fcpf_out_if  out_ch,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              eof;
	} framed_t;

	framed_t framed_q[$];

	logic [LEN_W-1:0]  pos_cnt;
	logic [PKT_W-1:0]  pkt_num;
	logic [BYTE_W-1:0] or_acc;
	logic [BYTE_W-1:0] xor_acc;

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eof, input logic summed);
		framed_t w;
		w.b   = b;
		w.eof = eof;
		framed_q.push_back(w);
		if (summed) begin
			or_acc  = or_acc | b;
			xor_acc = xor_acc ^ b;
		end
	endtask

	// expected bytes caused by one input word
	task automatic frame_word(input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len,
		input logic nf);
		logic [LEN_W-1:0] l;
		logic [15:0]      total_len;
		logic [15:0]      inner_len;
		l = len;
		if (l == 0)
			l = LEN_W'(1);
		else if (l > CHUNK_BYTES)
			l = LEN_W'(CHUNK_BYTES);
		if (pos_cnt == 0) begin
			total_len = 16'(l) + 16'(TOTAL_ADD);
			inner_len = 16'(l) + 16'(INNER_ADD);
			if (nf)
				pkt_num = '0;
			or_acc  = '0;
			xor_acc = '0;
			push_byte(total_len[15:8], 1'b0, 1'b0);
			push_byte(total_len[7:0], 1'b0, 1'b0);
			push_byte(HDR_PROTO, 1'b0, 1'b0);
			push_byte(HDR_ONE, 1'b0, 1'b1);
			push_byte(HDR_ONE, 1'b0, 1'b1);
			push_byte(inner_len[15:8], 1'b0, 1'b1);
			push_byte(inner_len[7:0], 1'b0, 1'b1);
			push_byte(HDR_ZERO, 1'b0, 1'b1);
			push_byte(pkt_num[15:8], 1'b0, 1'b1);
			push_byte(pkt_num[7:0], 1'b0, 1'b1);
		end
		push_byte(d, 1'b0, 1'b1);
		pos_cnt = pos_cnt + 1'b1;
		// trailer is not folded into the sums
		if (pos_cnt >= l) begin
			push_byte(or_acc, 1'b0, 1'b0);
			push_byte(xor_acc, 1'b1, 1'b0);
			pos_cnt = '0;
			pkt_num = pkt_num + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		framed_t exp_w;
		if (!arst_n) begin
			framed_q.delete();
			pos_cnt    = '0;
			pkt_num    = '0;
			or_acc     = '0;
			xor_acc    = '0;
			fail_count = 0;
			pending    = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				frame_word(in_ch.data_byte, in_ch.chunk_length, in_ch.new_file);
			if (out_ch.valid && out_ch.ready) begin
				if (framed_q.size() == 0) begin
					$error("unexpected output word: out_byte %0h end_of_frame %0b",
						out_ch.out_byte, out_ch.end_of_frame);
					fail_count = fail_count + 1;
				end else begin
					exp_w = framed_q.pop_front();
					if (out_ch.out_byte !== exp_w.b) begin
						$error("out_byte expected %0h actual %0h", exp_w.b, out_ch.out_byte);
						fail_count = fail_count + 1;
					end
					if (out_ch.end_of_frame !== exp_w.eof) begin
						$error("end_of_frame expected %0b actual %0b", exp_w.eof,
							out_ch.end_of_frame);
						fail_count = fail_count + 1;
					end
				end
			end
			pending = framed_q.size();
		end
	end

endmodule

// ----- sim/firmware_chunk_packet_framer_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for firmware_chunk_packet_framer_core: drives chunks of firmware
// bytes with random gaps and stalls, gives the verdict. Uses fcpf_pkg, fcpf_if, fcpf_frame_check.

module firmware_chunk_packet_framer_core_tb;
	import fcpf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   send_idle = 10;
	int   recv_idle = 50;
	int   rand_items = 0;

	fcpf_in_if  in_ch();
	fcpf_out_if out_ch();

	firmware_chunk_packet_framer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	fcpf_frame_check frame_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_idle);

	// starts and returns at a falling edge; valid stays high on return
	task automatic send_word(input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len,
		input logic nf);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.data_byte    <= d;
		in_ch.chunk_length <= len;
		in_ch.new_file     <= nf;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_frames();
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	// broken chunks change the length mid-chunk and toggle new_file on later words
	task automatic send_chunk(input bit broken);
		int               pos;
		int               eff;
		logic [LEN_W-1:0] len_now;
		logic             nf;
		pos = 0;
		eff = 1;
		len_now = LEN_W'(($urandom_range(9) == 0) ? $urandom_range(1, 48) :
			$urandom_range(1, 12));
		do begin
			if (pos == 0) begin
				if (broken && $urandom_range(2) == 0) begin
					case ($urandom_range(4))
						0: len_now = 10'd0;
						1: len_now = 10'd1023;
						2: len_now = LEN_W'(CHUNK_BYTES);
						3: len_now = LEN_W'(CHUNK_BYTES - 1);
						default: len_now = 10'd512;
					endcase
				end
				nf = ($urandom_range(7) == 0);
			end else begin
				nf = broken ? 1'($urandom_range(1)) : 1'b0;
				if (broken && (len_now > 60 || $urandom_range(2) == 0))
					len_now = LEN_W'($urandom_range(0, 30));
			end
			send_word(BYTE_W'($urandom_range(255)), len_now, nf);
			rand_items = rand_items + 1;
			pos = pos + 1;
			eff = (len_now == 0) ? 1 : ((len_now > CHUNK_BYTES) ? CHUNK_BYTES : len_now);
		end while (pos < eff);
	endtask

	initial begin
		in_ch.valid        = 1'b0;
		in_ch.data_byte    = '0;
		in_ch.chunk_length = '0;
		in_ch.new_file     = 1'b0;
		out_ch.ready       = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, zero and oversize lengths, mid-chunk changes
		send_word(8'h00, 10'd1, 1'b1);
		send_word(8'hFF, 10'd0, 1'b0);
		send_word(8'hA5, 10'd3, 1'b0);
		send_word(8'h5A, 10'd3, 1'b1);
		send_word(8'hFF, 10'd3, 1'b0);
		send_word(8'h12, 10'd1023, 1'b0);
		send_word(8'h34, 10'd2, 1'b0);
		send_word(8'h80, LEN_W'(CHUNK_BYTES), 1'b0);
		send_word(8'h7F, 10'd1, 1'b0);
		send_word(8'h55, 10'd512, 1'b0);
		send_word(8'hAA, 10'd0, 1'b0);
		send_word(8'h01, 10'd2, 1'b1);
		send_word(8'h02, 10'd2, 1'b0);
		send_word(8'hC3, 10'd5, 1'b0);
		send_word(8'h3C, 10'd3, 1'b0);
		send_word(8'h0F, 10'd3, 1'b0);
		drain_frames();

		while (rand_items < 145)
			send_chunk($urandom_range(99) < 20);
		drain_frames();

		send_idle = 50;
		recv_idle = 10;
		while (rand_items < 290)
			send_chunk($urandom_range(99) < 20);
		drain_frames();

		send_idle = 0;
		recv_idle = 0;
		while (rand_items < 414)
			send_chunk($urandom_range(99) < 20);
		drain_frames();

		if (fail_count == 0 && pending == 0)
			$display("firmware_chunk_packet_framer_core verification clean");
		else
			$display("firmware_chunk_packet_framer_core verification failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("firmware_chunk_packet_framer_core verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/fcpf_pkg.sv
src/fcpf_if.sv
src/fcpf_front.sv
src/fcpf_fifo.sv
src/fcpf_back.sv
src/firmware_chunk_packet_framer_core.sv
sim/fcpf_frame_check.sv
sim/firmware_chunk_packet_framer_core_tb.sv
